/* sv/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_BLOCKS_DEF = 32;

  localparam logic [15:0] ARENA_RESET  = 16'd10000;
  localparam logic [7:0]  HEADER_RESET = 8'd24;

  localparam logic CFG_ARENA  = 1'b0;
  localparam logic CFG_HEADER = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_ROOM    = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_t;

  // one row of the block table
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
  } entry_t;

endpackage

/* sv/first_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit allocator over a sorted table of blocks held in a single-port
// read / single-port write memory.
// ----------------------------------------------------------------------------
// Steps: allocate scans for the first gap, shifts later rows up, writes
//   the new row; free scans for the match, shifts later rows down; a full
//   table skips the scan. Scan and shift together pass each entry once,
//   and the table's one read port sets the pace at one entry per cycle.
// Throughput: one request at a time; the next is taken once the result is
//   registered, while the result still waits at the output.
// Reset: synchronous; empties the table (count cleared), restores registers.
module first_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        mode,
  input  logic [15:0] request_size,
  input  logic [15:0] block_address,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [15:0] data_address
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_PLACE,
    S_DONE
  } state_t;

  state_t state;

  logic [15:0] arena_size;
  logic [7:0]  header_size;

  logic [CW-1:0] count;
  logic          mode_q;
  logic [16:0]   need;
  logic [15:0]   addr_q;
  logic [CW-1:0] chk;
  logic [16:0]   prev_end;
  logic [IW-1:0] src;
  logic [IW-1:0] dst;
  logic [CW-1:0] rem;
  logic          pend;
  logic [IW-1:0] wa;
  logic [IW-1:0] slot;
  logic [15:0]   place;
  ffba_pkg::status_t res_st;
  logic [15:0]   res_ad;

  logic [IW-1:0]    rd_addr;
  ffba_pkg::entry_t rd_q;
  logic             tbl_we;
  logic [IW-1:0]    tbl_wa;
  ffba_pkg::entry_t tbl_wd;

  logic [CW-1:0] chk_p1;
  logic [CW-1:0] cnt_m1;
  logic          at_end;
  logic [16:0]   sum_a;
  logic [15:0]   minuend;
  logic [17:0]   diff;
  logic          fit;
  logic          match;

  assign chk_p1 = chk + CW'(1);
  assign cnt_m1 = count - CW'(1);
  assign at_end = (chk == count);

  // shared adder: end of this block on allocate, its data offset on free
  assign sum_a = {1'b0, rd_q.start} +
                 ((mode_q == ffba_pkg::MODE_FREE) ? {9'b0, header_size} : {1'b0, rd_q.length});
  assign match = (sum_a == {1'b0, addr_q});

  // shared subtractor: gap before this block, or tail space at the end
  assign minuend = at_end ? arena_size : rd_q.start;
  assign diff    = {2'b0, minuend} - {1'b0, prev_end};
  assign fit     = !diff[17] && (diff[16:0] >= need);

  assign req_stall = (state != S_IDLE);

  always_comb begin
    unique case (state)
      S_SCAN:  rd_addr = chk_p1[IW-1:0];
      S_MOVE:  rd_addr = src;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = wa;
    tbl_wd = rd_q;
    if (state == S_MOVE) begin
      tbl_we = pend;
    end else if (state == S_PLACE) begin
      tbl_we = 1'b1;
      tbl_wa = slot;
      tbl_wd = '{start: place, length: need[15:0]};
    end
  end

  ffba_table #(
    .DEPTH(MAX_BLOCKS),
    .IW   (IW)
  ) u_table (
    .clk    (clk),
    .rd_addr(rd_addr),
    .rd_data(rd_q),
    .we     (tbl_we),
    .wr_addr(tbl_wa),
    .wr_data(tbl_wd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_size  <= ffba_pkg::ARENA_RESET;
      header_size <= ffba_pkg::HEADER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffba_pkg::CFG_ARENA:  arena_size  <= cfg_data;
        ffba_pkg::CFG_HEADER: header_size <= cfg_data[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            mode_q   <= mode;
            need     <= {9'b0, header_size} + {1'b0, request_size};
            addr_q   <= block_address;
            chk      <= '0;
            prev_end <= '0;
            pend     <= 1'b0;
            if (mode == ffba_pkg::MODE_ALLOC && count == CW'(MAX_BLOCKS)) begin
              res_st <= ffba_pkg::ST_TABLE_FULL;
              res_ad <= '0;
              state  <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (mode_q == ffba_pkg::MODE_ALLOC) begin
            if (fit) begin
              place <= prev_end[15:0];
              slot  <= chk[IW-1:0];
              src   <= cnt_m1[IW-1:0];
              dst   <= count[IW-1:0];
              rem   <= count - chk;
              state <= S_MOVE;
            end else if (at_end) begin
              res_st <= ffba_pkg::ST_NO_ROOM;
              res_ad <= '0;
              state  <= S_DONE;
            end else begin
              prev_end <= sum_a;
              chk      <= chk_p1;
            end
          end else begin
            if (at_end) begin
              res_st <= ffba_pkg::ST_NOT_FOUND;
              res_ad <= '0;
              state  <= S_DONE;
            end else if (match) begin
              src   <= chk_p1[IW-1:0];
              dst   <= chk[IW-1:0];
              rem   <= count - chk_p1;
              state <= S_MOVE;
            end else begin
              chk <= chk_p1;
            end
          end
        end
        S_MOVE: begin
          // read one row ahead, write it one place over on the next cycle
          if (rem != '0) begin
            pend <= 1'b1;
            wa   <= dst;
            rem  <= rem - CW'(1);
            if (mode_q == ffba_pkg::MODE_ALLOC) begin
              src <= src - IW'(1);
              dst <= dst - IW'(1);
            end else begin
              src <= src + IW'(1);
              dst <= dst + IW'(1);
            end
          end else begin
            pend <= 1'b0;
            if (mode_q == ffba_pkg::MODE_ALLOC) begin
              state <= S_PLACE;
            end else begin
              count  <= cnt_m1;
              res_st <= ffba_pkg::ST_OK;
              res_ad <= '0;
              state  <= S_DONE;
            end
          end
        end
        S_PLACE: begin
          count  <= count + CW'(1);
          res_st <= ffba_pkg::ST_OK;
          res_ad <= place + {8'b0, header_size};
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid    <= 1'b1;
            status       <= res_st;
            data_address <= res_ad;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/ffba_table.sv */
// ----------------------------------------------------------------------------
// ffba_table
// Block table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffba_table #(
  parameter int DEPTH = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic [IW-1:0]    rd_addr,
  output ffba_pkg::entry_t rd_data,
  input  logic             we,
  input  logic [IW-1:0]    wr_addr,
  input  ffba_pkg::entry_t wr_data
);

  ffba_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* test/tb_first_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_unit
// Self-checking bench for the first-fit allocator. A short directed table
// covers the corner cases: exact fit, oversize, shrunk arena, zero-length
// blocks and a header change with live blocks. It is followed by random phases
// under several arena and header settings. Each result is compared with
// a fixed value or an in-bench model of the block table; both channels idle at random.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_unit;

  localparam int TABLE_DEPTH     = ffba_pkg::MAX_BLOCKS_DEF;
  localparam int IDLE_PCT        = 9;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int NUM_PHASES      = 7;
  // ~1200 requests plus stalls; generous margin
  localparam int CYCLE_LIMIT     = 800000;

  typedef struct {
    ffba_pkg::status_t st;
    logic [15:0]       addr;
  } alloc_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_FIXED} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic          reg_sel;
    logic [15:0]   reg_value;
    logic          md;
    logic [15:0]   size;
    logic [15:0]   addr;
    alloc_result_t want;
  } stim_row_t;

  typedef struct {
    logic [15:0] arena;
    logic [7:0]  header;
    int          alloc_pct;
    int          size_cap;
    bit          quiet;
  } phase_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic        cfg_index     = ffba_pkg::CFG_ARENA;
  logic [15:0] cfg_data      = 16'h0;
  logic        req_valid     = 1'b0;
  logic        req_stall;
  logic        mode          = ffba_pkg::MODE_ALLOC;
  logic [15:0] request_size  = 16'h0;
  logic [15:0] block_address = 16'h0;
  logic        res_valid;
  logic        res_stall     = 1'b0;
  logic [1:0]  status;
  logic [15:0] data_address;

  // model of the block table and registers
  logic [15:0] tbl_start [TABLE_DEPTH];
  logic [15:0] tbl_len   [TABLE_DEPTH];
  int unsigned tbl_count  = 0;
  logic [15:0] arena_cfg  = ffba_pkg::ARENA_RESET;
  logic [7:0]  header_cfg = ffba_pkg::HEADER_RESET;

  alloc_result_t awaited_results [$];
  stim_row_t     directed_rows [$];
  int            errors      = 0;
  int            cycle_count = 0;
  bit            quiet       = 1'b0;

  first_fit_block_allocator_unit #(.MAX_BLOCKS(TABLE_DEPTH)) dut (.*);

  always #5 clk = ~clk;

  function automatic alloc_result_t place_block(logic [15:0] size);
    int unsigned need, prev_end, gap, tail, s, place, slot, i;
    bit found;
    alloc_result_t r;
    r = '{ffba_pkg::ST_NO_ROOM, 16'h0};
    need = header_cfg + size;
    prev_end = 0;
    place = 0;
    found = 1'b0;
    if (tbl_count >= TABLE_DEPTH) begin
      r.st = ffba_pkg::ST_TABLE_FULL;
      return r;
    end
    for (slot = 0; slot < tbl_count; slot++) begin
      s = tbl_start[slot];
      gap = (s >= prev_end) ? s - prev_end : 0;
      if (gap >= need) begin
        place = prev_end;
        found = 1'b1;
        break;
      end
      prev_end = s + tbl_len[slot];
    end
    if (!found) begin
      // tail measured from the true end of the last block
      tail = (arena_cfg > prev_end) ? arena_cfg - prev_end : 0;
      if (tail >= need) begin
        place = prev_end;
        slot = tbl_count;
        found = 1'b1;
      end
    end
    if (!found) return r;
    for (i = tbl_count; i > slot; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_len[i]   = tbl_len[i-1];
    end
    tbl_start[slot] = place[15:0];
    tbl_len[slot]   = need[15:0];
    tbl_count++;
    r.st   = ffba_pkg::ST_OK;
    r.addr = 16'(place + header_cfg);
    return r;
  endfunction

  function automatic alloc_result_t release_block(logic [15:0] addr);
    int unsigned i, j;
    alloc_result_t r;
    r = '{ffba_pkg::ST_NOT_FOUND, 16'h0};
    for (i = 0; i < tbl_count; i++) begin
      // matched against the header in force now, not the one at allocation
      if (int'(tbl_start[i]) + int'(header_cfg) == int'(addr)) begin
        for (j = i; j + 1 < tbl_count; j++) begin
          tbl_start[j] = tbl_start[j+1];
          tbl_len[j]   = tbl_len[j+1];
        end
        tbl_count--;
        r.st = ffba_pkg::ST_OK;
        return r;
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_free_address();
    int unsigned k;
    int r;
    r = $urandom_range(99);
    if (tbl_count == 0 || r < 15) return 16'($urandom);
    k = $urandom_range(tbl_count - 1);
    if (r < 22) return 16'(tbl_start[k] + header_cfg + 1);
    return 16'(tbl_start[k] + header_cfg);
  endfunction

  function automatic logic [15:0] pick_size(int cap);
    int r;
    r = $urandom_range(99);
    if (r < 4) return 16'h0000;
    if (r < 7) return 16'hFFFF;
    if (r < 12) return 16'($urandom);
    return 16'($urandom_range(cap));
  endfunction

  function automatic stim_row_t req_row(logic md, logic [15:0] size, logic [15:0] addr);
    stim_row_t row;
    row = '{ROW_PREDICT, ffba_pkg::CFG_ARENA, 16'h0, md, size, addr,
            '{ffba_pkg::ST_OK, 16'h0}};
    return row;
  endfunction

  function automatic stim_row_t fixed_row(logic md, logic [15:0] size, logic [15:0] addr,
                                          ffba_pkg::status_t st, logic [15:0] da);
    stim_row_t row;
    row = '{ROW_FIXED, ffba_pkg::CFG_ARENA, 16'h0, md, size, addr, '{st, da}};
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic sel, logic [15:0] value);
    stim_row_t row;
    row = '{ROW_WRITE, sel, value, ffba_pkg::MODE_ALLOC, 16'h0, 16'h0,
            '{ffba_pkg::ST_OK, 16'h0}};
    return row;
  endfunction

  task automatic issue_request(logic md, logic [15:0] size, logic [15:0] addr,
                               bit fixed, alloc_result_t want);
    alloc_result_t got;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid     <= 1'b1;
    mode          <= md;
    request_size  <= size;
    block_address <= addr;
    do @(posedge clk); while (req_stall);
    got = (md == ffba_pkg::MODE_ALLOC) ? place_block(size) : release_block(addr);
    awaited_results.push_back(fixed ? want : got);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic sel, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == ffba_pkg::CFG_HEADER) header_cfg = value[7:0];
    else arena_cfg = value;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    res_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst && res_valid && !res_stall) begin
      if (awaited_results.size() == 0) begin
        $error("unrequested result: status %0d data_address %0d", status, data_address);
        errors++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (status !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, status);
          errors++;
        end
        if (data_address !== exp_r.addr) begin
          $error("data_address: expected %0d, got %0d", exp_r.addr, data_address);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    phase_t phases [NUM_PHASES];
    stim_row_t row;
    int p, n;

    phases[0] = '{16'd10000, 8'd24,  60, 600,   1'b0};
    phases[1] = '{16'd65535, 8'd0,   85, 400,   1'b0};  // fills the table
    phases[2] = '{16'd0,     8'd255, 50, 16,    1'b0};
    phases[3] = '{16'd1000,  8'd255, 55, 120,   1'b0};
    phases[4] = '{16'd65535, 8'd255, 65, 4000,  1'b1};  // no idling either side
    phases[5] = '{16'd300,   8'd8,   60, 40,    1'b0};
    phases[6] = '{16'd4096,  8'd16,  55, 300,   1'b0};

    // reset values: arena 10000, header 24
    directed_rows.push_back(fixed_row(ffba_pkg::MODE_ALLOC, 16'd0, 16'h0,
                                      ffba_pkg::ST_OK, 16'd24));
    directed_rows.push_back(fixed_row(ffba_pkg::MODE_FREE, 16'h0, 16'd24,
                                      ffba_pkg::ST_OK, 16'd0));
    directed_rows.push_back(fixed_row(ffba_pkg::MODE_FREE, 16'h0, 16'd24,
                                      ffba_pkg::ST_NOT_FOUND, 16'd0));
    directed_rows.push_back(fixed_row(ffba_pkg::MODE_ALLOC, 16'hFFFF, 16'h0,
                                      ffba_pkg::ST_NO_ROOM, 16'd0));
    directed_rows.push_back(fixed_row(ffba_pkg::MODE_ALLOC, 16'd9976, 16'h0,
                                      ffba_pkg::ST_OK, 16'd24));
    directed_rows.push_back(fixed_row(ffba_pkg::MODE_ALLOC, 16'd0, 16'h0,
                                      ffba_pkg::ST_NO_ROOM, 16'd0));
    directed_rows.push_back(fixed_row(ffba_pkg::MODE_FREE, 16'h0, 16'd24,
                                      ffba_pkg::ST_OK, 16'd0));
    directed_rows.push_back(req_row(ffba_pkg::MODE_ALLOC, 16'd100, 16'h0));
    directed_rows.push_back(req_row(ffba_pkg::MODE_ALLOC, 16'd200, 16'h0));
    directed_rows.push_back(req_row(ffba_pkg::MODE_ALLOC, 16'd50, 16'h0));
    directed_rows.push_back(req_row(ffba_pkg::MODE_FREE, 16'h0, 16'd148));
    // refills the hole exactly
    directed_rows.push_back(req_row(ffba_pkg::MODE_ALLOC, 16'd200, 16'h0));
    directed_rows.push_back(fixed_row(ffba_pkg::MODE_FREE, 16'h0, 16'hFFFF,
                                      ffba_pkg::ST_NOT_FOUND, 16'd0));
    directed_rows.push_back(fixed_row(ffba_pkg::MODE_FREE, 16'h0, 16'h0,
                                      ffba_pkg::ST_NOT_FOUND, 16'd0));
    // arena shrunk below the blocks already placed
    directed_rows.push_back(reg_row(ffba_pkg::CFG_ARENA, 16'd100));
    directed_rows.push_back(req_row(ffba_pkg::MODE_ALLOC, 16'd0, 16'h0));
    // zero-length block squeezes in at offset 0; frees now match header 0
    directed_rows.push_back(reg_row(ffba_pkg::CFG_HEADER, 16'd0));
    directed_rows.push_back(req_row(ffba_pkg::MODE_ALLOC, 16'd0, 16'h0));
    directed_rows.push_back(req_row(ffba_pkg::MODE_FREE, 16'h0, 16'd0));
    directed_rows.push_back(req_row(ffba_pkg::MODE_FREE, 16'h0, 16'd24));
    directed_rows.push_back(req_row(ffba_pkg::MODE_FREE, 16'h0, 16'd124));
    directed_rows.push_back(reg_row(ffba_pkg::CFG_HEADER, 16'd255));
    directed_rows.push_back(req_row(ffba_pkg::MODE_FREE, 16'h0, 16'd603));
    directed_rows.push_back(req_row(ffba_pkg::MODE_FREE, 16'h0, 16'd255));
    directed_rows.push_back(reg_row(ffba_pkg::CFG_ARENA, 16'hFFFF));
    directed_rows.push_back(req_row(ffba_pkg::MODE_ALLOC, 16'd65280, 16'h0));
    directed_rows.push_back(req_row(ffba_pkg::MODE_ALLOC, 16'hFFFF, 16'h0));
    directed_rows.push_back(req_row(ffba_pkg::MODE_FREE, 16'h0, 16'd255));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_WRITE: begin
          wait_idle();
          write_reg(row.reg_sel, row.reg_value);
        end
        default: issue_request(row.md, row.size, row.addr, row.kind == ROW_FIXED, row.want);
      endcase
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_reg(ffba_pkg::CFG_ARENA, phases[p].arena);
      // upper data bits are not part of the header register
      write_reg(ffba_pkg::CFG_HEADER, {8'($urandom), phases[p].header});
      quiet = phases[p].quiet;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < phases[p].alloc_pct)
          issue_request(ffba_pkg::MODE_ALLOC, pick_size(phases[p].size_cap),
                        16'($urandom), 1'b0, '{ffba_pkg::ST_OK, 16'h0});
        else
          issue_request(ffba_pkg::MODE_FREE, 16'($urandom), pick_free_address(),
                        1'b0, '{ffba_pkg::ST_OK, 16'h0});
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
